### sv/etb_pkg.sv
// Shared types and constants of the event timer block.
// Register map offsets, field bit positions, beat payloads and the structs
// that pass between the core and the timer slices. No dependencies.
package etb_pkg;

  localparam int TMR_COUNT  = 8;
  localparam int CAP_MASK_W = 8;

  // func codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // register map (byte offsets, 64-bit words)
  localparam logic [10:0] REG_CAPS    = 11'h000;
  localparam logic [10:0] REG_GCONF   = 11'h010;
  localparam logic [10:0] REG_STATUS  = 11'h020;
  localparam logic [10:0] REG_COUNTER = 11'h0F0;
  localparam logic [10:0] REG_TIMER0  = 11'h100;
  localparam int          TIMER_STRIDE = 32'h20;
  localparam int          TIMER_BLK0   = REG_TIMER0 / TIMER_STRIDE;
  localparam logic [4:0]  SUB_CONF    = 5'h00;
  localparam logic [4:0]  SUB_CMP     = 5'h08;

  // timer config bit positions
  localparam int TC_LEVEL    = 1;
  localparam int TC_ENABLE   = 2;
  localparam int TC_PERIODIC = 3;
  localparam int TC_PER_CAP  = 4;
  localparam int TC_WIDE_CAP = 5;
  localparam int TC_VALSET   = 6;
  localparam int TC_MODE32   = 8;
  localparam int TC_FSB      = 14;
  localparam int TC_FSB_CAP  = 15;

  // configuration register indexes
  localparam logic [2:0] CFG_TICK_PERIOD = 3'd0;
  localparam logic [2:0] CFG_VENDOR      = 3'd1;
  localparam logic [2:0] CFG_REVISION    = 3'd2;
  localparam logic [2:0] CFG_LEGACY_CAP  = 3'd3;
  localparam logic [2:0] CFG_PERIODIC    = 3'd4;
  localparam logic [2:0] CFG_WIDE        = 3'd5;
  localparam logic [2:0] CFG_FSB         = 3'd6;
  localparam logic [2:0] CFG_ROUTE       = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] address;
    logic [63:0] write_data;
  } etb_in_t;

  typedef struct packed {
    logic [63:0]          read_data;
    logic [TMR_COUNT-1:0] irq_lines;
  } etb_out_t;

  typedef struct packed {
    logic [26:0]           tick_period_fs;
    logic [15:0]           vendor_code;
    logic [7:0]            revision_code;
    logic                  legacy_capable;
    logic [CAP_MASK_W-1:0] periodic_capable_mask;
    logic [CAP_MASK_W-1:0] wide_capable_mask;
    logic [CAP_MASK_W-1:0] fsb_capable_mask;
    logic [31:0]           route_capability;
  } etb_cfg_t;

  localparam etb_cfg_t CFG_RESET = '{
    tick_period_fs:        27'd69841279,
    vendor_code:           16'd32902,
    revision_code:         8'd1,
    legacy_capable:        1'b1,
    periodic_capable_mask: 8'h01,
    wide_capable_mask:     8'hFF,
    fsb_capable_mask:      8'h00,
    route_capability:      32'h0
  };

  typedef struct packed {
    logic level;
    logic enable;
    logic periodic;
    logic valset;
    logic mode32;
    logic fsb;
  } etb_tset_t;

  // core to timer slice
  typedef struct packed {
    logic        tick;
    logic        wr_conf;
    logic        wr_cmp;
    logic [63:0] wdata;
    logic [63:0] count_inc;
    logic        per_cap;
    logic        wide_cap;
    logic        fsb_cap;
    logic [31:0] route;
  } etb_tcmd_t;

  // timer slice to core
  typedef struct packed {
    logic        hit;
    logic        enable_nxt;
    logic        level_nxt;
    logic [63:0] conf_rd;
    logic [63:0] cmp_rd;
  } etb_tstat_t;

endpackage

### sv/etb_timer.sv
// One timer slice: settings, comparator and period registers, match logic.
// Depends on etb_pkg for the command and status structs.
module etb_timer (
  input  logic               clk,
  input  logic               rst_n,
  input  etb_pkg::etb_tcmd_t cmd,
  output etb_pkg::etb_tstat_t stat
);
  import etb_pkg::*;

  etb_tset_t   set_r, set_nxt;
  logic [63:0] cmp_r, cmp_nxt;
  logic [63:0] per_r, per_nxt;
  logic        narrow;
  logic        periodic;
  logic        hit;
  logic [63:0] sum;
  logic [63:0] wd;

  always_comb begin
    narrow   = !cmd.wide_cap || set_r.mode32;
    periodic = cmd.per_cap && set_r.periodic;
    hit      = cmd.tick && (narrow ? (cmd.count_inc[31:0] == cmp_r[31:0])
                                   : (cmd.count_inc == cmp_r));
    sum      = cmp_r + per_r;
    wd       = narrow ? {32'b0, cmd.wdata[31:0]} : cmd.wdata;

    set_nxt = set_r;
    cmp_nxt = cmp_r;
    per_nxt = per_r;

    if (hit && periodic) begin
      cmp_nxt = narrow ? {32'b0, sum[31:0]} : sum;
    end

    if (cmd.wr_conf) begin
      set_nxt.level    = cmd.wdata[TC_LEVEL];
      set_nxt.enable   = cmd.wdata[TC_ENABLE];
      set_nxt.periodic = cmd.wdata[TC_PERIODIC];
      set_nxt.valset   = cmd.wdata[TC_VALSET];
      set_nxt.mode32   = cmd.wdata[TC_MODE32];
      set_nxt.fsb      = cmd.wdata[TC_FSB];
    end

    if (cmd.wr_cmp) begin
      if (set_r.valset) begin
        cmp_nxt        = wd;
        per_nxt        = wd;
        set_nxt.valset = 1'b0;
      end else if (periodic) begin
        per_nxt = wd;
      end else begin
        cmp_nxt = wd;
      end
    end
  end

  always_comb begin
    stat.hit        = hit;
    stat.enable_nxt = set_nxt.enable;
    stat.level_nxt  = set_nxt.level;
    stat.conf_rd    = {cmd.route, 32'b0};
    stat.conf_rd[TC_LEVEL]    = set_r.level;
    stat.conf_rd[TC_ENABLE]   = set_r.enable;
    stat.conf_rd[TC_PERIODIC] = periodic;
    stat.conf_rd[TC_PER_CAP]  = cmd.per_cap;
    stat.conf_rd[TC_WIDE_CAP] = cmd.wide_cap;
    stat.conf_rd[TC_MODE32]   = cmd.wide_cap && set_r.mode32;
    stat.conf_rd[TC_FSB_CAP]  = cmd.fsb_cap;
    stat.conf_rd[TC_FSB]      = cmd.fsb_cap && set_r.fsb;
    stat.cmp_rd     = narrow ? {32'b0, cmp_r[31:0]} : cmp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= '0;
      cmp_r <= '1;
      per_r <= '0;
    end else begin
      set_r <= set_nxt;
      cmp_r <= cmp_nxt;
      per_r <= per_nxt;
    end
  end

endmodule

### sv/etb_core.sv
// Register file of the event timer: global config, status, main counter,
// address decode, read mux and the timer slices. Depends on etb_pkg, etb_timer.
module etb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  etb_pkg::etb_in_t  item,
  input  etb_pkg::etb_cfg_t cfg,
  output etb_pkg::etb_out_t result
);
  import etb_pkg::*;

  logic                 ge_r, ge_nxt;
  logic                 lr_r, lr_nxt;
  logic [63:0]          count_r, count_nxt;
  logic [63:0]          count_inc;
  logic [TMR_COUNT-1:0] status_r, status_nxt;
  logic [10:0]          addr;
  logic                 is_tick;
  logic                 is_write;
  logic                 is_read;
  logic [TMR_COUNT-1:0] sel;
  logic [TMR_COUNT-1:0] hitv;
  logic [TMR_COUNT-1:0] en_nxt;
  logic [TMR_COUNT-1:0] lvl_nxt;
  logic [63:0]          timer_rd;
  logic [63:0]          rd;

  etb_tcmd_t  tcmd [TMR_COUNT];
  etb_tstat_t tstat[TMR_COUNT];

  assign addr      = {item.address[10:3], 3'b000};
  assign is_tick   = step && (item.func == FUNC_TICK) && ge_r;
  assign is_write  = step && (item.func == FUNC_WRITE);
  assign is_read   = item.func == FUNC_READ;
  assign count_inc = count_r + 64'd1;

  for (genvar i = 0; i < TMR_COUNT; i++) begin : g_timer
    assign sel[i] = addr[10:5] == 6'(TIMER_BLK0 + i);

    always_comb begin
      tcmd[i].tick      = is_tick;
      tcmd[i].wr_conf   = is_write && sel[i] && (addr[4:0] == SUB_CONF);
      tcmd[i].wr_cmp    = is_write && sel[i] && (addr[4:0] == SUB_CMP);
      tcmd[i].wdata     = item.write_data;
      tcmd[i].count_inc = count_inc;
      tcmd[i].per_cap   = cfg.periodic_capable_mask[i];
      tcmd[i].wide_cap  = cfg.wide_capable_mask[i];
      tcmd[i].fsb_cap   = cfg.fsb_capable_mask[i];
      tcmd[i].route     = cfg.route_capability;
    end

    etb_timer u_timer (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (tcmd[i]),
      .stat (tstat[i])
    );

    assign hitv[i]    = tstat[i].hit;
    assign en_nxt[i]  = tstat[i].enable_nxt;
    assign lvl_nxt[i] = tstat[i].level_nxt;
  end

  // selected timer word, zero when nothing in the timer window matches
  always_comb begin
    timer_rd = '0;
    for (int i = 0; i < TMR_COUNT; i++) begin
      if (sel[i] && (addr[4:0] == SUB_CONF)) timer_rd = timer_rd | tstat[i].conf_rd;
      if (sel[i] && (addr[4:0] == SUB_CMP))  timer_rd = timer_rd | tstat[i].cmp_rd;
    end
  end

  always_comb begin
    case (addr)
      REG_CAPS: begin
        rd = {5'b0, cfg.tick_period_fs, cfg.vendor_code, cfg.legacy_capable, 1'b0, 1'b1,
              5'(TMR_COUNT - 1), cfg.revision_code};
      end
      REG_GCONF:   rd = {62'b0, lr_r && cfg.legacy_capable, ge_r};
      REG_STATUS:  rd = 64'(status_r);
      REG_COUNTER: rd = count_r;
      default:     rd = timer_rd;
    endcase
  end

  always_comb begin
    ge_nxt     = ge_r;
    lr_nxt     = lr_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (is_tick) begin
      count_nxt  = count_inc;
      status_nxt = status_r | hitv;
    end
    if (is_write) begin
      case (addr)
        REG_GCONF: begin
          ge_nxt = item.write_data[0];
          lr_nxt = cfg.legacy_capable && item.write_data[1];
        end
        REG_STATUS:  status_nxt = status_r & ~item.write_data[TMR_COUNT-1:0];
        REG_COUNTER: count_nxt  = item.write_data;
        default: ;
      endcase
    end
  end

  // lines follow the state as it stands after this beat
  always_comb begin
    result.read_data = is_read ? rd : 64'b0;
    result.irq_lines = ge_nxt ? (en_nxt & ((lvl_nxt & status_nxt) | (~lvl_nxt & hitv)))
                              : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r     <= 1'b0;
      lr_r     <= 1'b0;
      count_r  <= '0;
      status_r <= '0;
    end else if (step) begin
      ge_r     <= ge_nxt;
      lr_r     <= lr_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

### sv/event_timer_block_registers_top.sv
// Top level of the event timer block: input register, core, result register
// and the configuration registers. Depends on etb_pkg and etb_core.
//
// Usage:
//   in_*  : valid/ready channel carrying etb_in_t beats (tick, read, write).
//   out_* : valid/ready channel carrying one etb_out_t beat per input beat,
//           in order: read data for reads, zero otherwise, plus irq lines.
//   cfg_* : write-only port for the capability registers, one write per
//           cycle with cfg_we high, to be written only while the block is idle.
// An input beat is captured in the input register, executed against the
// register file once the result register is free, and its result lands
// in the output register, which drives out_valid and out_data. One beat
// per cycle is sustained while the receiver keeps out_ready high; the
// single execute step (counter increment, per-timer compare and periodic
// add, read mux) sets that rate.
// A stalled receiver holds the result register; the input register still
// takes one more beat, then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, stops the counter,
// clears status and timer settings, sets comparators to all ones and loads
// the capability defaults.
module event_timer_block_registers_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  etb_pkg::etb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output etb_pkg::etb_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import etb_pkg::*;

  logic     in_valid_r;
  etb_in_t  in_item_r;
  logic     out_valid_r;
  etb_out_t out_item_r;
  etb_out_t result;
  etb_cfg_t cfg_r;
  logic     out_free;
  logic     step;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  etb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: cfg_r.tick_period_fs        <= cfg_wdata[26:0];
        CFG_VENDOR:      cfg_r.vendor_code           <= cfg_wdata[15:0];
        CFG_REVISION:    cfg_r.revision_code         <= cfg_wdata[7:0];
        CFG_LEGACY_CAP:  cfg_r.legacy_capable        <= cfg_wdata[0];
        CFG_PERIODIC:    cfg_r.periodic_capable_mask <= cfg_wdata[CAP_MASK_W-1:0];
        CFG_WIDE:        cfg_r.wide_capable_mask     <= cfg_wdata[CAP_MASK_W-1:0];
        CFG_FSB:         cfg_r.fsb_capable_mask      <= cfg_wdata[CAP_MASK_W-1:0];
        CFG_ROUTE:       cfg_r.route_capability      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
